// File: sv/ptc_pkg.sv
// Shared constants and saturation helper for the pooled t contrast block.
`default_nettype none

package ptc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int LIMIT_W     = 21;
   localparam int OUT_W       = 48;
   localparam int DOF_W       = 17;
   localparam int MEAN_W      = 32;
   localparam int DEV_W       = 32;
   localparam int COUNT_W     = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd999999;
   localparam int HUNDRED = 100;

   // Percent error: quotient and root widths; percent change quotient width.
   localparam int PE_QUOT_W = 96;
   localparam int PE_ROOT_W = 48;
   localparam int PC_QUOT_W = 48;

   localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAG = 64'h0000_8000_0000_0000;

   // Apply a sign to a magnitude and clamp to the 48-bit signed range.
   function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [63:0] mag);
      logic [63:0] m;
      logic [63:0] r;
      if (neg) begin
         m = (mag > NEG_MAG) ? NEG_MAG : mag;
         r = 64'd0 - m;
      end else begin
         m = (mag > POS_MAX) ? POS_MAX : mag;
         r = m;
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/ptc_delay.sv
// Fixed-length register delay line with a shared advance enable.
`default_nettype none

module ptc_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] din,
   output logic      [W-1:0] dout
);

   logic [W-1:0] pipe_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int k = 1; k < N; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   assign dout = pipe_ff[N-1];

endmodule

`default_nettype wire

// File: sv/ptc_mul.sv
// Pipelined multiplier: one slice of the B operand multiplied and accumulated per cell.
`default_nettype none

module ptc_mul #(
   parameter int WA     = 32,
   parameter int WB     = 16,
   parameter int STAGES = 2
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [WA-1:0]      a,
   input  wire logic [WB-1:0]      b,
   output logic      [WA+WB-1:0]   p
);

   localparam int WP = WA + WB;
   localparam int CH = (WB + STAGES - 1) / STAGES;
   localparam int BP = CH * STAGES;

   logic [WA-1:0] a_ff   [STAGES];
   logic [BP-1:0] b_ff   [STAGES];
   logic [WP-1:0] acc_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      logic [WA-1:0]    a_src;
      logic [BP-1:0]    b_src;
      logic [WP-1:0]    acc_src;
      logic [WA+CH-1:0] part;

      if (k == 0) begin : g_first
         assign a_src   = a;
         assign b_src   = BP'(b);
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[k-1];
         assign b_src   = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end

      assign part = (WA+CH)'(a_src) * (WA+CH)'(b_src[CH*k +: CH]);

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k]   <= a_src;
            b_ff[k]   <= b_src;
            acc_ff[k] <= acc_src + (WP'(part) << (CH*k));
         end
      end
   end

   assign p = acc_ff[STAGES-1];

endmodule

`default_nettype wire

// File: sv/ptc_div.sv
// Restoring divider as a chain of cells, one quotient bit per cell, with overflow detect.
`default_nettype none

module ptc_div #(
   parameter int ND = 64,
   parameter int DW = 32,
   parameter int QW = 32
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [ND-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic      [QW-1:0] quot,
   output logic               ovf
);

   localparam int XW = (ND > DW + QW) ? ND : DW + QW;

   logic [XW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic          ovf_ff [QW+1];

   // Head cell: flag a quotient that does not fit in QW bits.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= XW'(dividend);
         den_ff[0] <= divisor;
         quo_ff[0] <= '0;
         ovf_ff[0] <= XW'(dividend) >= (XW'(divisor) << QW);
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_cell
      localparam int SH = QW - 1 - j;
      logic [XW-1:0] trial;
      logic          take;

      assign trial = XW'(den_ff[j]) << SH;
      assign take  = rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= take ? rem_ff[j] - trial : rem_ff[j];
            den_ff[j+1] <= den_ff[j];
            quo_ff[j+1] <= quo_ff[j] | (QW'(take) << SH);
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign quot = quo_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule

`default_nettype wire

// File: sv/ptc_sqrt.sv
// Integer square root as a chain of cells, one root bit per cell.
`default_nettype none

module ptc_sqrt #(
   parameter int RW = 16
) (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [2*RW-1:0] x,
   output logic      [RW-1:0]   root
);

   localparam int SW = 2 * RW + 1;

   logic [SW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_cell
      localparam int B = RW - 1 - j;
      logic [SW-1:0] rem_src;
      logic [RW-1:0] root_src;
      logic [SW-1:0] trial;
      logic          take;

      if (j == 0) begin : g_first
         assign rem_src  = SW'(x);
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
      end

      // (q + 2^b)^2 - q^2 = q*2^(b+1) + 4^b
      assign trial = (SW'(root_src) << (B + 1)) | (SW'(1) << (2 * B));
      assign take  = rem_src >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= take ? rem_src - trial : rem_src;
            root_ff[j] <= root_src | (RW'(take) << B);
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

`default_nettype wire

// File: sv/pooled_t_contrast.sv
// Top level of the pooled two-sample t contrast pipeline.
`default_nettype none

// Per-pixel contrast of two conditions. Each item carries two means, two
// sample deviations and two image counts; each result carries the pooled
// t-statistic (clamped to +/- t_limit), the percent signal change, its
// leading-order error, the degrees of freedom and a data-sufficiency flag.
// One item enters per cycle while the pipeline is not held; the depth of the
// pipeline is set by the percent-error path: a restoring divider of 96
// quotient cells followed by a 48-cell square root, one bit per cell. The t
// path (division of 2*(21+FRAC_BITS) bits, then a root) is padded to the
// same depth. A two-entry output buffer lets one more item in while a
// result waits; the whole pipeline holds only when both entries are full.
// The t_limit register is written through the csr_ port, always ready.
module pooled_t_contrast
   import ptc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [LIMIT_W-1:0]        csr_t_limit,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [MEAN_W-1:0]  req_mean_first,
   input  wire logic signed [MEAN_W-1:0]  req_mean_second,
   input  wire logic [DEV_W-1:0]          req_dev_first,
   input  wire logic [DEV_W-1:0]          req_dev_second,
   input  wire logic [COUNT_W-1:0]        req_count_first,
   input  wire logic [COUNT_W-1:0]        req_count_second,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [OUT_W-1:0]        rsp_t_stat,
   output logic signed [OUT_W-1:0]        rsp_pct_change,
   output logic signed [OUT_W-1:0]        rsp_pct_error,
   output logic [DOF_W-1:0]               rsp_dof,
   output logic                           rsp_enough_data
);

   // Widths that follow from the parameters.
   localparam int F    = FRAC_BITS;
   localparam int CW   = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
   localparam int CAPW = LIMIT_W + F;
   localparam int K1W  = 2 * CW + 1;
   localparam int KW   = 3 * CW + 1;
   localparam int CPW  = 2 * CW;
   localparam int SNW  = 64 + CW;
   localparam int NSW  = 65 + CW;
   localparam int NW   = NSW + CW + 1;
   localparam int FW   = 64 + CPW;
   localparam int RHW  = 66 + KW;
   localparam int NTW  = RHW + 2 * F;
   localparam int VBW  = NSW + 14;
   localparam int NEW  = VBW + 2 * F;
   localparam int NCW  = 40 + F;
   localparam int TQW  = 2 * CAPW;

   // Pipeline depths (stage index of each value).
   localparam int ST_DIV = 9;
   localparam int T_OVF  = ST_DIV + 1 + TQW;
   localparam int T_END  = T_OVF + CAPW;
   localparam int E_OVF  = ST_DIV + 1 + PE_QUOT_W;
   localparam int C_END  = ST_DIV + 1 + PC_QUOT_W;
   localparam int FIN    = E_OVF + PE_ROOT_W;

   localparam logic [13:0] TEN_THOUSAND = 14'(HUNDRED * HUNDRED);
   localparam logic [63:0] HUND_Q       = 64'(HUNDRED) << F;

   typedef struct packed {
      logic             dneg;
      logic             mneg;
      logic             dnz;
      logic             m2z;
      logic             enough;
      logic [DOF_W-1:0] dof;
   } flags_type;

   typedef struct packed {
      logic [OUT_W-1:0] t_stat;
      logic [OUT_W-1:0] pct_change;
      logic [OUT_W-1:0] pct_error;
      logic [DOF_W-1:0] dof;
      logic             enough;
   } rsp_type;

   logic en;

   // ---------------- configuration ----------------
   logic [LIMIT_W-1:0] t_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         t_limit_ff <= csr_t_limit;
      end
   end

   // ---------------- stage 1: signs, magnitudes, counts ----------------
   logic [32:0]    diff_in;
   logic [32:0]    dmag_in;
   logic [31:0]    m2u_in;
   logic [31:0]    mmag_in;
   logic [CW-1:0]  c1_in;
   logic [CW-1:0]  c2_in;
   logic [CW:0]    csum_in;
   flags_type      flags_in;

   always_comb begin
      diff_in  = {req_mean_first[31], req_mean_first} - {req_mean_second[31], req_mean_second};
      dmag_in  = diff_in[32] ? 33'd0 - diff_in : diff_in;
      m2u_in   = req_mean_second;
      mmag_in  = m2u_in[31] ? 32'd0 - m2u_in : m2u_in;
      c1_in    = req_count_first[CW-1:0];
      c2_in    = req_count_second[CW-1:0];
      csum_in  = (CW+1)'(c1_in) + (CW+1)'(c2_in);
      flags_in.dneg   = diff_in[32];
      flags_in.mneg   = m2u_in[31];
      flags_in.dnz    = diff_in != 33'd0;
      flags_in.m2z    = m2u_in == 32'd0;
      flags_in.enough = (c1_in != '0) && (c2_in != '0) && (csum_in > (CW+1)'(2));
      flags_in.dof    = flags_in.enough ? DOF_W'(csum_in - (CW+1)'(2)) : '0;
   end

   logic [31:0]   s1_d1_ff, s1_d2_ff, s1_mmag_ff;
   logic [32:0]   s1_dmag_ff;
   logic [CW-1:0] s1_c1_ff, s1_c2_ff;
   logic [CW:0]   s1_csum_ff;
   flags_type     s1_flags_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d1_ff    <= req_dev_first;
         s1_d2_ff    <= req_dev_second;
         s1_mmag_ff  <= mmag_in;
         s1_dmag_ff  <= dmag_in;
         s1_c1_ff    <= c1_in;
         s1_c2_ff    <= c2_in;
         s1_csum_ff  <= csum_in;
         s1_flags_ff <= flags_in;
      end
   end

   // ---------------- stage 2: squares and count products ----------------
   logic [63:0]    s2_d1sq_ff, s2_d2sq_ff, s2_msq_ff;
   logic [65:0]    s2_dm2_ff;
   logic [K1W-1:0] s2_k1_ff;
   logic [CPW-1:0] s2_c12_ff;
   logic [CW-1:0]  s2_c1m1_ff, s2_c2m1_ff, s2_c1_ff, s2_c2_ff;
   logic [CW:0]    s2_csum_ff;
   logic [NCW-1:0] s2_pcnum_ff;
   logic [31:0]    s2_mmag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_d1sq_ff  <= 64'(s1_d1_ff) * 64'(s1_d1_ff);
         s2_d2sq_ff  <= 64'(s1_d2_ff) * 64'(s1_d2_ff);
         s2_msq_ff   <= 64'(s1_mmag_ff) * 64'(s1_mmag_ff);
         s2_dm2_ff   <= 66'(s1_dmag_ff) * 66'(s1_dmag_ff);
         s2_k1_ff    <= K1W'(s1_csum_ff - (CW+1)'(2)) * K1W'(s1_c1_ff);
         s2_c12_ff   <= CPW'(s1_c1_ff) * CPW'(s1_c2_ff);
         s2_c1m1_ff  <= s1_c1_ff - CW'(1);
         s2_c2m1_ff  <= s1_c2_ff - CW'(1);
         s2_c1_ff    <= s1_c1_ff;
         s2_c2_ff    <= s1_c2_ff;
         s2_csum_ff  <= s1_csum_ff;
         s2_pcnum_ff <= NCW'(40'(s1_dmag_ff) * 40'(HUNDRED)) << F;
         s2_mmag_ff  <= s1_mmag_ff;
      end
   end

   // ---------------- stages 3-4: first multiplier row ----------------
   logic [SNW-1:0] s1p, s2p, v1p, v2p;
   logic [KW-1:0]  kp;
   logic [FW-1:0]  facp;

   ptc_mul #(.WA(64), .WB(CW), .STAGES(2)) u_mul_s1 (
      .clock(clock), .en(en), .a(s2_d1sq_ff), .b(s2_c1m1_ff), .p(s1p));
   ptc_mul #(.WA(64), .WB(CW), .STAGES(2)) u_mul_s2 (
      .clock(clock), .en(en), .a(s2_d2sq_ff), .b(s2_c2m1_ff), .p(s2p));
   ptc_mul #(.WA(64), .WB(CW), .STAGES(2)) u_mul_v1 (
      .clock(clock), .en(en), .a(s2_d1sq_ff), .b(s2_c2_ff), .p(v1p));
   ptc_mul #(.WA(64), .WB(CW), .STAGES(2)) u_mul_v2 (
      .clock(clock), .en(en), .a(s2_d2sq_ff), .b(s2_c1_ff), .p(v2p));
   ptc_mul #(.WA(K1W), .WB(CW), .STAGES(2)) u_mul_k (
      .clock(clock), .en(en), .a(s2_k1_ff), .b(s2_c2_ff), .p(kp));
   ptc_mul #(.WA(64), .WB(CPW), .STAGES(2)) u_mul_fac (
      .clock(clock), .en(en), .a(s2_msq_ff), .b(s2_c12_ff), .p(facp));

   // Carry operands that skip the first or the second multiplier row.
   logic [65:0]    dm2_d;
   logic [CW:0]    csum_d;
   logic [FW-1:0]  fac_d;
   logic [NCW-1:0] pcnum_d;
   logic [31:0]    mmag_d;

   ptc_delay #(.W(66), .N(3)) u_dly_dm2 (
      .clock(clock), .en(en), .din(s2_dm2_ff), .dout(dm2_d));
   ptc_delay #(.W(CW+1), .N(3)) u_dly_csum (
      .clock(clock), .en(en), .din(s2_csum_ff), .dout(csum_d));
   ptc_delay #(.W(FW), .N(ST_DIV-4)) u_dly_fac (
      .clock(clock), .en(en), .din(facp), .dout(fac_d));
   ptc_delay #(.W(NCW), .N(ST_DIV-2)) u_dly_pcnum (
      .clock(clock), .en(en), .din(s2_pcnum_ff), .dout(pcnum_d));
   ptc_delay #(.W(32), .N(ST_DIV-2)) u_dly_mmag (
      .clock(clock), .en(en), .din(s2_mmag_ff), .dout(mmag_d));

   // ---------------- stage 5: sums ----------------
   logic [NSW-1:0] s5_nsum_ff, s5_vsum_ff;
   logic [KW-1:0]  s5_k_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_nsum_ff <= NSW'(s1p) + NSW'(s2p);
         s5_vsum_ff <= NSW'(v1p) + NSW'(v2p);
         s5_k_ff    <= kp;
      end
   end

   // ---------------- stages 6-9: second multiplier row ----------------
   logic [RHW-1:0] rhs_p;
   logic [NW-1:0]  n_p;
   logic [VBW-1:0] vb_p;

   ptc_mul #(.WA(66), .WB(KW), .STAGES(4)) u_mul_rhs (
      .clock(clock), .en(en), .a(dm2_d), .b(s5_k_ff), .p(rhs_p));
   ptc_mul #(.WA(NSW), .WB(CW+1), .STAGES(4)) u_mul_n (
      .clock(clock), .en(en), .a(s5_nsum_ff), .b(csum_d), .p(n_p));
   ptc_mul #(.WA(NSW), .WB(14), .STAGES(4)) u_mul_vb (
      .clock(clock), .en(en), .a(s5_vsum_ff), .b(TEN_THOUSAND), .p(vb_p));

   // ---------------- division and root chains ----------------
   logic [TQW-1:0]       t_quo;
   logic                 t_ovf;
   logic [CAPW-1:0]      t_root;
   logic [PE_QUOT_W-1:0] pe_quo;
   logic                 pe_ovf;
   logic [PE_ROOT_W-1:0] pe_root;
   logic [PC_QUOT_W-1:0] pc_quo;
   logic                 pc_ovf;

   ptc_div #(.ND(NTW), .DW(NW), .QW(TQW)) u_div_t (
      .clock(clock), .en(en), .dividend(NTW'(rhs_p) << (2*F)), .divisor(n_p),
      .quot(t_quo), .ovf(t_ovf));
   ptc_sqrt #(.RW(CAPW)) u_sqrt_t (
      .clock(clock), .en(en), .x(t_quo), .root(t_root));

   ptc_div #(.ND(NEW), .DW(FW), .QW(PE_QUOT_W)) u_div_pe (
      .clock(clock), .en(en), .dividend(NEW'(vb_p) << (2*F)), .divisor(fac_d),
      .quot(pe_quo), .ovf(pe_ovf));
   ptc_sqrt #(.RW(PE_ROOT_W)) u_sqrt_pe (
      .clock(clock), .en(en), .x(pe_quo), .root(pe_root));

   ptc_div #(.ND(NCW), .DW(32), .QW(PC_QUOT_W)) u_div_pc (
      .clock(clock), .en(en), .dividend(pcnum_d), .divisor(mmag_d),
      .quot(pc_quo), .ovf(pc_ovf));

   // Align everything to the last stage.
   logic [$bits(flags_type)-1:0] flags_vec;
   flags_type                    flags_fin;
   logic                         vzero_fin, nzero_fin, t_ovf_fin, pe_ovf_fin;
   logic [CAPW-1:0]              t_root_fin;
   logic [PC_QUOT_W:0]           pc_fin;

   ptc_delay #(.W($bits(flags_type)), .N(FIN-1)) u_dly_flags (
      .clock(clock), .en(en), .din(s1_flags_ff), .dout(flags_vec));
   ptc_delay #(.W(1), .N(FIN-5)) u_dly_vzero (
      .clock(clock), .en(en), .din(s5_vsum_ff == '0), .dout(vzero_fin));
   ptc_delay #(.W(1), .N(FIN-ST_DIV)) u_dly_nzero (
      .clock(clock), .en(en), .din(n_p == '0), .dout(nzero_fin));
   ptc_delay #(.W(1), .N(FIN-T_OVF)) u_dly_tovf (
      .clock(clock), .en(en), .din(t_ovf), .dout(t_ovf_fin));
   ptc_delay #(.W(CAPW), .N(FIN-T_END)) u_dly_troot (
      .clock(clock), .en(en), .din(t_root), .dout(t_root_fin));
   ptc_delay #(.W(1), .N(FIN-E_OVF)) u_dly_peovf (
      .clock(clock), .en(en), .din(pe_ovf), .dout(pe_ovf_fin));
   ptc_delay #(.W(PC_QUOT_W+1), .N(FIN-C_END)) u_dly_pc (
      .clock(clock), .en(en), .din({pc_ovf, pc_quo}), .dout(pc_fin));

   assign flags_fin = flags_type'(flags_vec);

   // ---------------- result assembly ----------------
   logic [CAPW-1:0]      tcap;
   logic [CAPW-1:0]      t_mag;
   logic [PE_ROOT_W-1:0] pe_cap;
   logic [PE_ROOT_W-1:0] pe_mag;
   rsp_type              res_in;

   always_comb begin
      tcap   = CAPW'(t_limit_ff) << F;
      pe_cap = PE_ROOT_W'(NEG_MAG);

      // Undefined t: no data, zero pooled deviation or zero difference.
      if (!flags_fin.enough || nzero_fin || !flags_fin.dnz) begin
         t_mag = flags_fin.dnz ? tcap : '0;
      end else if (t_ovf_fin || t_root_fin > tcap) begin
         t_mag = tcap;
      end else begin
         t_mag = t_root_fin;
      end

      pe_mag = (pe_ovf_fin || pe_root > pe_cap) ? pe_cap : pe_root;

      res_in.t_stat = sat_out(flags_fin.dneg, 64'(t_mag));

      if (!flags_fin.enough || flags_fin.m2z) begin
         res_in.pct_change = sat_out(flags_fin.dneg, flags_fin.dnz ? HUND_Q : 64'd0);
      end else begin
         res_in.pct_change = sat_out(flags_fin.dneg != flags_fin.mneg && flags_fin.dnz,
                                     64'(pc_fin));
      end

      if (!flags_fin.enough) begin
         res_in.pct_error = OUT_W'(HUND_Q);
      end else if (flags_fin.m2z) begin
         res_in.pct_error = vzero_fin ? '0 : OUT_W'(POS_MAX);
      end else begin
         res_in.pct_error = sat_out(flags_fin.mneg && pe_mag != '0, 64'(pe_mag));
      end

      res_in.dof    = flags_fin.dof;
      res_in.enough = flags_fin.enough;
   end

   // ---------------- valid tracking ----------------
   logic [FIN:1] valid_ff;
   logic         push;
   logic         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[FIN-1:1], req_valid};
      end
   end

   // ---------------- two-entry output buffer ----------------
   rsp_type    head_ff, skid_ff;
   logic [1:0] count_ff;

   assign en        = count_ff != 2'd2;
   assign req_ready = en;
   assign push      = valid_ff[FIN] && en;
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!push && pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push && (count_ff == 2'd0 || (count_ff == 2'd1 && pop))) begin
         head_ff <= res_in;
      end else if (pop) begin
         head_ff <= skid_ff;
      end
      if (push && count_ff == 2'd1 && !pop) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid       = count_ff != 2'd0;
   assign rsp_t_stat      = head_ff.t_stat;
   assign rsp_pct_change  = head_ff.pct_change;
   assign rsp_pct_error   = head_ff.pct_error;
   assign rsp_dof         = head_ff.dof;
   assign rsp_enough_data = head_ff.enough;

endmodule

`default_nettype wire

// File: sim/pooled_t_contrast_checker.sv
// Checker for the pooled t contrast block: predicts each result and compares it.
`timescale 1ns / 100ps

module pooled_t_contrast_checker
   import ptc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [LIMIT_W-1:0]       csr_t_limit,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic signed [MEAN_W-1:0] req_mean_first,
   input  wire logic signed [MEAN_W-1:0] req_mean_second,
   input  wire logic [DEV_W-1:0]         req_dev_first,
   input  wire logic [DEV_W-1:0]         req_dev_second,
   input  wire logic [COUNT_W-1:0]       req_count_first,
   input  wire logic [COUNT_W-1:0]       req_count_second,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [OUT_W-1:0]  rsp_t_stat,
   input  wire logic signed [OUT_W-1:0]  rsp_pct_change,
   input  wire logic signed [OUT_W-1:0]  rsp_pct_error,
   input  wire logic [DOF_W-1:0]         rsp_dof,
   input  wire logic                     rsp_enough_data,
   output int                            fail_count,
   output int                            pending
);

   typedef struct {
      logic signed [OUT_W-1:0] t_stat;
      logic signed [OUT_W-1:0] pct_change;
      logic signed [OUT_W-1:0] pct_error;
      logic [DOF_W-1:0]        dof;
      logic                    enough_data;
   } contrast_type;

   contrast_type         expected_q[$];
   logic [LIMIT_W-1:0]   limit_shadow;

   function automatic logic [OUT_W-1:0] clamp48(input logic neg, input logic [63:0] mag);
      logic [63:0] m;
      if (neg) begin
         m = (mag > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : mag;
         m = 64'd0 - m;
      end else begin
         m = (mag > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : mag;
      end
      return m[OUT_W-1:0];
   endfunction

   // Largest q <= cap with q*q*fac <= rhs, found bit by bit.
   function automatic logic [63:0] root_floor(input logic [255:0] rhs,
                                              input logic [255:0] fac,
                                              input logic [63:0] cap);
      logic [63:0]  q;
      logic [63:0]  c;
      logic [255:0] cx;
      logic [255:0] sq;
      q = 0;
      for (int b = 47; b >= 0; b--) begin
         c = q | (64'd1 << b);
         if (c <= cap) begin
            cx = c;
            sq = cx * cx * fac;
            if (sq <= rhs) q = c;
         end
      end
      return q;
   endfunction

   function automatic contrast_type contrast(input logic signed [MEAN_W-1:0] mf,
                                             input logic signed [MEAN_W-1:0] ms,
                                             input logic [DEV_W-1:0] df,
                                             input logic [DEV_W-1:0] ds,
                                             input logic [COUNT_W-1:0] cf,
                                             input logic [COUNT_W-1:0] cs,
                                             input logic [LIMIT_W-1:0] lim);
      contrast_type       r;
      logic signed [63:0] m1, m2, diff;
      logic [63:0]        dmag, mmag, tcap, hund, num, tmag, pe, c1, c2, d1, d2, dof;
      logic [255:0]       n, rhs, v, fac;
      logic               dneg, mneg, enough;
      m1 = mf;
      m2 = ms;
      d1 = df;
      d2 = ds;
      c1 = cf;
      c2 = cs;
      diff = m1 - m2;
      dneg = diff < 0;
      dmag = dneg ? 64'(-diff) : 64'(diff);
      mneg = m2 < 0;
      mmag = mneg ? 64'(-m2) : 64'(m2);
      tcap = 64'(lim) << 16;
      hund = 64'd100 << 16;
      enough = (c1 != 0) && (c2 != 0) && (c1 + c2 > 2);
      if (!enough) begin
         r.t_stat      = clamp48(dneg, diff != 0 ? tcap : 64'd0);
         r.pct_change  = clamp48(dneg, diff != 0 ? hund : 64'd0);
         r.pct_error   = hund[OUT_W-1:0];
         r.dof         = '0;
         r.enough_data = 1'b0;
         return r;
      end
      dof = c1 + c2 - 2;
      n = (256'(d1 * d1) * (c1 - 1) + 256'(d2 * d2) * (c2 - 1)) * (c1 + c2);
      if (n == 0 || diff == 0) begin
         tmag = (diff != 0) ? tcap : 64'd0;
      end else begin
         rhs = ((256'(dmag) * dmag) << 32) * dof * c1 * c2;
         tmag = root_floor(rhs, n, tcap);
      end
      r.t_stat = clamp48(dneg, tmag);
      if (m2 == 0) begin
         r.pct_change = clamp48(dneg, diff != 0 ? hund : 64'd0);
      end else begin
         num = (dmag * 64'd100) << 16;
         r.pct_change = clamp48((dneg != mneg) && diff != 0, num / mmag);
      end
      v = 256'(d1 * d1) * c2 + 256'(d2 * d2) * c1;
      if (m2 == 0) begin
         r.pct_error = (v == 0) ? '0 : 48'h7FFF_FFFF_FFFF;
      end else begin
         fac = 256'(c1 * c2) * mmag * mmag;
         pe = root_floor((v * 10000) << 32, fac, 64'h8000_0000_0000);
         r.pct_error = clamp48(mneg && pe != 0, pe);
      end
      r.dof         = dof[DOF_W-1:0];
      r.enough_data = 1'b1;
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      contrast_type e;
      if (reset) begin
         limit_shadow <= LIMIT_RESET;
         fail_count   <= 0;
      end else begin
         if (csr_valid && csr_ready) limit_shadow <= csr_t_limit;
         if (req_valid && req_ready)
            expected_q.push_back(contrast(req_mean_first, req_mean_second, req_dev_first,
                                          req_dev_second, req_count_first,
                                          req_count_second, limit_shadow));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no item waiting");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_t_stat !== e.t_stat || rsp_pct_change !== e.pct_change ||
                   rsp_pct_error !== e.pct_error || rsp_dof !== e.dof ||
                   rsp_enough_data !== e.enough_data)
                  fail_count <= fail_count + 1;
               if (rsp_t_stat !== e.t_stat)
                  $error("t_stat expected %0d actual %0d", e.t_stat, rsp_t_stat);
               if (rsp_pct_change !== e.pct_change)
                  $error("pct_change expected %0d actual %0d", e.pct_change, rsp_pct_change);
               if (rsp_pct_error !== e.pct_error)
                  $error("pct_error expected %0d actual %0d", e.pct_error, rsp_pct_error);
               if (rsp_dof !== e.dof)
                  $error("dof expected %0d actual %0d", e.dof, rsp_dof);
               if (rsp_enough_data !== e.enough_data)
                  $error("enough_data expected %0d actual %0d", e.enough_data,
                         rsp_enough_data);
            end
         end
      end
   end

endmodule

// File: sim/pooled_t_contrast_tb.sv
// Stimulus and verdict for the pooled t contrast block.
`timescale 1ns / 100ps

module pooled_t_contrast_tb;
   import ptc_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [LIMIT_W-1:0]       csr_t_limit = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [MEAN_W-1:0] req_mean_first = '0;
   logic signed [MEAN_W-1:0] req_mean_second = '0;
   logic [DEV_W-1:0]         req_dev_first = '0;
   logic [DEV_W-1:0]         req_dev_second = '0;
   logic [COUNT_W-1:0]       req_count_first = '0;
   logic [COUNT_W-1:0]       req_count_second = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]  rsp_t_stat;
   logic signed [OUT_W-1:0]  rsp_pct_change;
   logic signed [OUT_W-1:0]  rsp_pct_error;
   logic [DOF_W-1:0]         rsp_dof;
   logic                     rsp_enough_data;
   int                       fail_count;
   int                       pending;
   int                       idle_cycles = 0;
   int                       stall_left = 0;

   always #4 clock = ~clock;

   pooled_t_contrast DUT (.*);

   pooled_t_contrast_checker checker_i (.*);

   // Receiver: hold rsp_ready low for random stretches, mostly short, a few long.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(99) < 25) begin
         stall_left <= ($urandom_range(19) == 0) ? $urandom_range(60, 20)
                                                 : $urandom_range(3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Drive one item and hold it until accepted; valid stays high afterwards unless a gap follows.
   task automatic push_pixel(input logic [31:0] mf, input logic [31:0] ms,
                             input logic [31:0] df, input logic [31:0] ds,
                             input logic [15:0] cf, input logic [15:0] cs);
      int gap;
      req_valid        <= 1'b1;
      req_mean_first   <= mf;
      req_mean_second  <= ms;
      req_dev_first    <= df;
      req_dev_second   <= ds;
      req_count_first  <= cf;
      req_count_second <= cs;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      // Insert a random gap after the item; no gap keeps the stream back to back.
      gap = ($urandom_range(99) < 60) ? 0 :
            ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain every outstanding result, then let the pipeline settle.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain();
      csr_valid   <= 1'b1;
      csr_t_limit <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_mean;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         2: return 32'($signed($urandom_range(65535)) - 32768);
         default: return 32'($signed($urandom_range(400000)) - 200000) <<< 8;
      endcase
   endfunction

   function automatic logic [31:0] rand_dev;
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'd0;
         2: return $urandom_range(65535);
         default: return 32'($urandom_range(100)) << 16 | 32'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [15:0] rand_count;
      case ($urandom_range(9))
         0: return 16'($urandom_range(3));
         1: return 16'($urandom);
         default: return 16'($urandom_range(60, 2));
      endcase
   endfunction

   task automatic random_pixels(input int count);
      for (int i = 0; i < count; i++)
         push_pixel(rand_mean(), rand_mean(), rand_dev(), rand_dev(),
                    rand_count(), rand_count());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset limit.
      push_pixel(32'h0001_0000, 32'h0000_0000, 0, 0, 0, 5);              // count zero
      push_pixel(32'h0000_0000, 32'h0002_0000, 5, 5, 1, 1);              // total of two
      push_pixel(32'h0003_0000, 32'h0003_0000, 5, 5, 0, 0);              // no data, no diff
      push_pixel(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 0, 1, 2);
      push_pixel(32'h0005_0000, 32'h0002_0000, 0, 0, 10, 10);            // zero pooled dev
      push_pixel(32'h0002_0000, 32'h0005_0000, 0, 0, 3, 4);
      push_pixel(32'h0002_0000, 32'h0002_0000, 0, 0, 3, 4);              // zero everything
      push_pixel(32'h0004_0000, 32'h0000_0000, 32'h0001_0000, 0, 8, 8);  // zero second mean
      push_pixel(32'hFFFC_0000, 32'h0000_0000, 0, 0, 8, 8);
      push_pixel(32'h0000_0000, 32'h0000_0000, 0, 0, 8, 8);
      push_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      push_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF, 2);
      push_pixel(32'h7FFF_FFFF, 32'h0000_0001, 0, 1, 2, 16'hFFFF);       // huge ratio
      push_pixel(32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 2, 2);
      push_pixel(32'h0000_0001, 32'h0000_0000, 1, 0, 2, 1);
      push_pixel(32'h0010_0000, 32'h000F_0000, 32'h0000_0001, 32'h0000_0001, 30, 30);
      push_pixel(32'hFFF0_0000, 32'hFFF8_0000, 32'h0002_0000, 32'h0003_0000, 12, 9);
      push_pixel(32'h0000_8000, 32'h0000_4000, 32'h0000_0100, 32'h0000_0200, 4, 3);

      write_limit(21'd0);
      random_pixels(100);
      write_limit(21'd2000000);
      random_pixels(150);
      write_limit(21'd1);
      random_pixels(100);
      write_limit(21'($urandom_range(2000000)));
      random_pixels(100);
      drain();                       // pause the sender until every result is back
      random_pixels(100);
      write_limit(21'd1048575);
      random_pixels(20);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
